### hw/rtl/ring_divide_mod_pow2_macros.svh
// Assertion macros used by the checker of the ring divider.
`ifndef RING_DIVIDE_MOD_POW2_MACROS_SVH
`define RING_DIVIDE_MOD_POW2_MACROS_SVH

// Property checked at every rising edge outside reset.
`define RDM_ASSERT(LBL, CLK, RST_N, PROP, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) PROP) else $error(MSG);

// Condition in one cycle implies a condition in the next cycle.
`define RDM_ASSERT_NEXT(LBL, CLK, RST_N, COND, NEXT, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) (COND) |=> (NEXT)) \
		else $error(MSG);

`endif

### hw/rtl/rdm_pkg.sv
`default_nettype none

package rdm_pkg;

	localparam int DATA_W     = 32;
	localparam int TZ_W       = 5;
	localparam int K_W        = 6;
	// log2 of DATA_W factors (1 + x^(2^i)) give the inverse modulo 2^DATA_W.
	localparam int INV_ROUNDS = 5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DIV_ZERO  = 2'd1,
		ST_BAD_ZEROS = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		status_t           status;
	} rsp_t;

	// Per-item data that rides along the inversion rounds.
	typedef struct packed {
		logic [DATA_W-1:0] ao;
		logic [TZ_W-1:0]   sh;
		status_t           status;
		logic [K_W-1:0]    k;
	} side_t;

endpackage

`default_nettype wire

### hw/rtl/rdm_front.sv
`default_nettype none

module rdm_front #(
	parameter int MAX_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  rdm_pkg::req_t               req,
	input  logic [rdm_pkg::K_W-1:0]     modulus_bits,
	output logic                        out_valid,
	output logic [rdm_pkg::DATA_W-1:0]  x,
	output rdm_pkg::side_t              side
);
	import rdm_pkg::*;

	function automatic logic [TZ_W-1:0] trailing_zeros(input logic [DATA_W-1:0] v);
		logic [TZ_W-1:0] n;
		n = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (v[i]) n = TZ_W'(i);
		end
		return n;
	endfunction

	logic [K_W-1:0]    k_eff;
	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] a_in;
	logic [DATA_W-1:0] b_in;
	logic [TZ_W-1:0]   za_in;
	logic [TZ_W-1:0]   zb_in;
	status_t           status_in;

	logic              valid_s1;
	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic [TZ_W-1:0]   za_s1;
	logic [TZ_W-1:0]   zb_s1;
	status_t           status_s1;
	logic [K_W-1:0]    k_s1;

	logic              valid_s2;
	logic [DATA_W-1:0] x_s2;
	side_t             side_s2;

	always_comb begin
		k_eff = modulus_bits;
		if (modulus_bits == '0) begin
			k_eff = K_W'(1);
		end else if (int'(modulus_bits) > MAX_BITS) begin
			k_eff = K_W'(MAX_BITS);
		end
	end

	always_comb begin
		mask = '1;
		if (k_eff < K_W'(DATA_W)) mask = ~({DATA_W{1'b1}} << k_eff);
	end

	assign a_in  = req.dividend & mask;
	assign b_in  = req.divisor & mask;
	assign za_in = trailing_zeros(a_in);
	assign zb_in = trailing_zeros(b_in);

	always_comb begin
		status_in = ST_OK;
		if (b_in == '0) begin
			status_in = ST_DIV_ZERO;
		end else if (a_in != '0 && za_in < zb_in) begin
			status_in = ST_BAD_ZEROS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a_in;
			b_s1      <= b_in;
			za_s1     <= za_in;
			zb_s1     <= zb_in;
			status_s1 <= status_in;
			k_s1      <= k_eff;
		end
	end

	// A failed or zero dividend leaves a zero odd part, so the product is zero.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2           <= DATA_W'(1) - (b_s1 >> zb_s1);
			side_s2.ao     <= (status_s1 == ST_OK) ? (a_s1 >> za_s1) : '0;
			side_s2.sh     <= za_s1 - zb_s1;
			side_s2.status <= status_s1;
			side_s2.k      <= k_s1;
		end
	end

	assign out_valid = valid_s2;
	assign x         = x_s2;
	assign side      = side_s2;

endmodule

`default_nettype wire

### hw/rtl/rdm_round.sv
`default_nettype none

module rdm_round #(
	parameter bit SQUARE = 1'b1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rdm_pkg::DATA_W-1:0]  u_in,
	input  logic [rdm_pkg::DATA_W-1:0]  x_in,
	input  rdm_pkg::side_t              side_in,
	output logic                        out_valid,
	output logic [rdm_pkg::DATA_W-1:0]  u_out,
	output logic [rdm_pkg::DATA_W-1:0]  x_out,
	output rdm_pkg::side_t              side_out
);
	import rdm_pkg::*;

	logic              valid_s;
	logic [DATA_W-1:0] u_s;
	side_t             side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	// Products are kept modulo 2^DATA_W.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s    <= u_in * (x_in + DATA_W'(1));
			side_s <= side_in;
		end
	end

	generate
		if (SQUARE) begin : g_square
			logic [DATA_W-1:0] x_s;
			always_ff @(posedge clk) begin
				if (en) x_s <= x_in * x_in;
			end
			assign x_out = x_s;
		end else begin : g_no_square
			assign x_out = '0;
		end
	endgenerate

	assign out_valid = valid_s;
	assign u_out     = u_s;
	assign side_out  = side_s;

endmodule

`default_nettype wire

### hw/rtl/rdm_back.sv
`default_nettype none

module rdm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rdm_pkg::DATA_W-1:0]  inv,
	input  rdm_pkg::side_t              side_in,
	output logic                        out_valid,
	output rdm_pkg::rsp_t               rsp
);
	import rdm_pkg::*;

	logic              valid_s8;
	logic [DATA_W-1:0] p_s8;
	logic [TZ_W-1:0]   sh_s8;
	status_t           status_s8;
	logic [K_W-1:0]    k_s8;
	logic [DATA_W-1:0] mask;

	logic              valid_s9;
	rsp_t              rsp_s9;

	always_comb begin
		mask = '1;
		if (k_s8 < K_W'(DATA_W)) mask = ~({DATA_W{1'b1}} << k_s8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s8 <= in_valid;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s8      <= side_in.ao * inv;
			sh_s8     <= side_in.sh;
			status_s8 <= side_in.status;
			k_s8      <= side_in.k;
			rsp_s9.quotient <= (status_s8 == ST_OK) ? ((p_s8 << sh_s8) & mask) : '0;
			rsp_s9.status   <= status_s8;
		end
	end

	assign out_valid = valid_s9;
	assign rsp       = rsp_s9;

endmodule

`default_nettype wire

### hw/rtl/ring_divide_mod_pow2.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | dividend, divisor
// rsp     | out       | rsp_valid/rsp_stall | quotient, status
// cfg     | in        | cfg_valid/cfg_ready | modulus_bits (cfg_data)
//
// One word is taken per cycle unless a stalled result freezes the pipeline.
// The nine stages are two of operand split, five inversion rounds (two multipliers each,
// one in the last), the dividend multiply and the final shift and mask.
// Reset clears the stage valid bits and sets modulus_bits to 16.
// A stalled result freezes the whole pipeline, and req_stall rises with it.
`default_nettype none

module ring_divide_mod_pow2 #(
	parameter int MAX_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  rdm_pkg::req_t            req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rdm_pkg::rsp_t            rsp,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [rdm_pkg::K_W-1:0]  cfg_data
);
	import rdm_pkg::*;

	logic              en;
	logic [K_W-1:0]    modulus_bits_q;

	logic              valid_r [0:INV_ROUNDS];
	logic [DATA_W-1:0] u_r     [0:INV_ROUNDS];
	logic [DATA_W-1:0] x_r     [0:INV_ROUNDS-1];
	side_t             side_r  [0:INV_ROUNDS];

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_bits_q <= K_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			modulus_bits_q <= cfg_data;
		end
	end

	rdm_front #(
		.MAX_BITS(MAX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (req_valid),
		.req          (req),
		.modulus_bits (modulus_bits_q),
		.out_valid    (valid_r[0]),
		.x            (x_r[0]),
		.side         (side_r[0])
	);

	assign u_r[0] = DATA_W'(1);

	// Round r multiplies in (1 + x^(2^r)); the last one needs no further square.
	generate
		for (genvar r = 0; r < INV_ROUNDS; r++) begin : g_round
			if (r < INV_ROUNDS - 1) begin : g_mid
				rdm_round #(
					.SQUARE(1'b1)
				) u_round (
					.clk       (clk),
					.arst_n    (arst_n),
					.en        (en),
					.in_valid  (valid_r[r]),
					.u_in      (u_r[r]),
					.x_in      (x_r[r]),
					.side_in   (side_r[r]),
					.out_valid (valid_r[r+1]),
					.u_out     (u_r[r+1]),
					.x_out     (x_r[r+1]),
					.side_out  (side_r[r+1])
				);
			end else begin : g_last
				rdm_round #(
					.SQUARE(1'b0)
				) u_round (
					.clk       (clk),
					.arst_n    (arst_n),
					.en        (en),
					.in_valid  (valid_r[r]),
					.u_in      (u_r[r]),
					.x_in      (x_r[r]),
					.side_in   (side_r[r]),
					.out_valid (valid_r[r+1]),
					.u_out     (u_r[r+1]),
					.x_out     (),
					.side_out  (side_r[r+1])
				);
			end
		end
	endgenerate

	rdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_r[INV_ROUNDS]),
		.inv       (u_r[INV_ROUNDS]),
		.side_in   (side_r[INV_ROUNDS]),
		.out_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### hw/rtl/rdm_checker.sv
`default_nettype none
`include "ring_divide_mod_pow2_macros.svh"

module rdm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_stall,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input rdm_pkg::rsp_t   rsp
);
	import rdm_pkg::*;

	// A flagged division always reports a zero quotient.
	`RDM_ASSERT(a_err_quotient_zero, clk, arst_n, rsp_valid && rsp.status != ST_OK |-> rsp.quotient == '0, "quotient not zero on error")

	// A waiting result must hold back the input side.
	`RDM_ASSERT(a_stall_back, clk, arst_n, rsp_valid && rsp_stall |-> req_stall, "input taken while result stalled")

	`RDM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind ring_divide_mod_pow2 rdm_checker u_rdm_checker (.*);

`default_nettype wire
